FILE: sv/adcsf_pkg.sv
// Shared types, constants and helper functions for the ADC channel sequencer filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package adcsf_pkg;

  localparam int IDX_W   = 3;
  localparam int VAL_W   = 12;
  localparam int SHIFT_W = 4;
  localparam int INTV_W  = 16;
  localparam int FSUM_W  = 21;
  localparam int MUX_W   = 5;
  localparam int FILTERS = 4;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd4;
  localparam logic [INTV_W-1:0]  INTV_RST  = 16'd4000;

  // Measurement indices of the two temperature sensors.
  localparam logic [IDX_W-1:0] IDX_INT = 3'd4;
  localparam logic [IDX_W-1:0] IDX_EXT = 3'd5;

  // Converter mux codes.
  localparam logic [MUX_W-1:0] MUX_CH0      = 5'd5;
  localparam logic [MUX_W-1:0] MUX_CH1      = 5'd1;
  localparam logic [MUX_W-1:0] MUX_CH2      = 5'd2;
  localparam logic [MUX_W-1:0] MUX_CH3      = 5'd3;
  localparam logic [MUX_W-1:0] MUX_INTERNAL = 5'd27;
  localparam logic [MUX_W-1:0] MUX_EXTERNAL = 5'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VSHIFT   = 2'd0;
  localparam logic [1:0] REG_CSHIFT   = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  typedef struct packed {
    logic [SHIFT_W-1:0] voltage_shift;
    logic [SHIFT_W-1:0] current_shift;
    logic [INTV_W-1:0]  temp_interval;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted input word
    logic exec;      // apply the item to filter, history and sequence state
    logic sum_en;    // add one history entry to the accumulator
    logic div_load;  // add the rounding half to the history sum
    logic div_step;  // scale the sum by the reciprocal of the history depth
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic temp_avg;  // latched item is a normal temperature reading
    logic sum_last;  // last history entry is being added
  } status_t;

  function automatic logic [MUX_W-1:0] mux_code_of(input logic [IDX_W-1:0] idx);
    logic [MUX_W-1:0] code;
    case (idx)
      3'd0:    code = MUX_CH0;
      3'd1:    code = MUX_CH1;
      3'd2:    code = MUX_CH2;
      3'd3:    code = MUX_CH3;
      IDX_INT: code = MUX_INTERNAL;
      default: code = MUX_EXTERNAL;
    endcase
    return code;
  endfunction

  function automatic logic [SHIFT_W-1:0] shift_sat(input logic [SHIFT_W-1:0] k);
    return (k > MAX_SHIFT) ? MAX_SHIFT : k;
  endfunction

endpackage

FILE: sv/adc_channel_sequencer_filter_top.sv
// Top level of the ADC channel sequencer filter: configuration registers,
// stream ports and output register around adcsf_ctrl and adcsf_datapath.
// Depends on adcsf_pkg, adcsf_ctrl and adcsf_datapath.
//
//   Channel  Direction  Handshake             Contents
//   in_      slave      tvalid/tready         tdata: prime_index, sample; tuser: kind
//   out_     master     tvalid/tready         tdata: updated_index, updated_value,
//                                             next_index, mux_code
//   cfg_     APB slave  psel/penable/pready   voltage_shift, current_shift,
//                                             temp_interval at 0x0, 0x4, 0x8
//
// A filter word or a prime passes from IDLE through EXEC to DONE, where it is
// loaded into the output register; the next word is accepted only back in IDLE.
// A normal temperature word also passes through SUM, DLOAD and DIV on its way
// to DONE: the history sum adds one stored sample per cycle, DLOAD adds the
// rounding half and DIV multiplies by the reciprocal of SAMPLES.
// Reset (rst_n low, synchronous) clears filters, histories and sequence state.
// The output register lets the next input word be accepted while a result waits;
// if a result is still held when the next one is done, the controller waits.
module adc_channel_sequencer_filter_top #(
  parameter int SAMPLES     = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] prime_index, [14:3] sample, [15] zero
  input  logic [0:0]  in_tuser,   // [0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] updated_index, [14:3] updated_value,
                                  // [17:15] next_index, [22:18] mux_code, [23] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  adcsf_pkg::cfg_t    cfg_r, cfg_nxt;
  adcsf_pkg::cmd_t    cmd;
  adcsf_pkg::status_t status;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        out_load;
  logic        cfg_write;

  logic [adcsf_pkg::IDX_W-1:0] res_index, next_index;
  logic [adcsf_pkg::VAL_W-1:0] res_value;
  logic [adcsf_pkg::MUX_W-1:0] mux_code;

  // Registers are written in the access phase; the port never stalls.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (cfg_paddr[3:2])
        adcsf_pkg::REG_VSHIFT:   cfg_nxt.voltage_shift = cfg_pwdata[3:0];
        adcsf_pkg::REG_CSHIFT:   cfg_nxt.current_shift = cfg_pwdata[3:0];
        adcsf_pkg::REG_INTERVAL: cfg_nxt.temp_interval = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      adcsf_pkg::REG_VSHIFT:   cfg_prdata = {28'd0, cfg_r.voltage_shift};
      adcsf_pkg::REG_CSHIFT:   cfg_prdata = {28'd0, cfg_r.current_shift};
      adcsf_pkg::REG_INTERVAL: cfg_prdata = {16'd0, cfg_r.temp_interval};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_shift <= adcsf_pkg::SHIFT_RST;
      cfg_r.current_shift <= adcsf_pkg::SHIFT_RST;
      cfg_r.temp_interval <= adcsf_pkg::INTV_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (!out_valid_r || out_tready),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  adcsf_datapath #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg_r),
    .in_kind        (in_tuser[0]),
    .in_prime_index (in_tdata[2:0]),
    .in_sample      (in_tdata[14:3]),
    .res_index      (res_index),
    .res_value      (res_value),
    .next_index     (next_index),
    .mux_code       (mux_code)
  );

  // Output register: the result word waits here until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, mux_code, next_index, res_value, res_index};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/adcsf_ctrl.sv
// Controller state machine of the ADC channel sequencer filter.
// Drives adcsf_datapath through adcsf_pkg::cmd_t and reads adcsf_pkg::status_t.
module adcsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output logic              out_load,
  input  adcsf_pkg::status_t status,
  output adcsf_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.temp_avg ? S_SUM : S_DONE;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (status.sum_last) begin
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/adcsf_datapath.sv
// Datapath of the ADC channel sequencer filter: leaky integrators, temperature
// history with serial sum and reciprocal-multiply average, and the channel sequence.
// Depends on adcsf_pkg; commanded by adcsf_ctrl.
module adcsf_datapath #(
  parameter int SAMPLES     = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  adcsf_pkg::cmd_t                   cmd,
  output adcsf_pkg::status_t                status,
  input  adcsf_pkg::cfg_t                   cfg,
  input  logic                              in_kind,
  input  logic [adcsf_pkg::IDX_W-1:0]       in_prime_index,
  input  logic [adcsf_pkg::VAL_W-1:0]       in_sample,
  output logic [adcsf_pkg::IDX_W-1:0]       res_index,
  output logic [adcsf_pkg::VAL_W-1:0]       res_value,
  output logic [adcsf_pkg::IDX_W-1:0]       next_index,
  output logic [adcsf_pkg::MUX_W-1:0]       mux_code
);

  localparam int VAL_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int SLOT_W  = $clog2(SAMPLES);
  localparam int DIV_W   = adcsf_pkg::VAL_W + $clog2(SAMPLES) + 1;
  localparam int CNT_W   = SLOT_W;
  localparam int CMP_W   = 17;
  localparam int FW      = adcsf_pkg::FSUM_W;
  localparam int VW      = adcsf_pkg::VAL_W;
  localparam int IW      = adcsf_pkg::IDX_W;

  // Division by SAMPLES as a multiply by a rounded-up reciprocal; exact for any
  // sum below 2^DIV_W because the shift carries clog2(SAMPLES) extra bits.
  localparam int RSH = DIV_W + SLOT_W;
  localparam int RW  = DIV_W + 1;
  localparam int PW  = DIV_W + RW;
  localparam int QW  = PW - RSH;
  localparam logic [RW-1:0] RECIP = RW'(((1 << RSH) + SAMPLES - 1) / SAMPLES);

  // Latched input word.
  logic          kind_r, kind_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [VW-1:0] samp_r, samp_nxt;

  // Filter and history state.
  logic [FW-1:0] fsum_r [adcsf_pkg::FILTERS];
  logic [FW-1:0] fsum_nxt [adcsf_pkg::FILTERS];
  logic [VW-1:0] hist_r [2][SAMPLES];
  logic [VW-1:0] hist_nxt [2][SAMPLES];
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // Sequence state.
  logic [IW-1:0]                    cur_r, cur_nxt;
  logic [IW-1:0]                    saved_r, saved_nxt;
  logic [adcsf_pkg::INTV_W-1:0]     cd_r, cd_nxt;
  logic                             last_ext_r, last_ext_nxt;

  // Average unit.
  logic             tsel_r, tsel_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] acc_r, acc_nxt;

  // Result.
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic [VW-1:0] rval_r, rval_nxt;

  logic [adcsf_pkg::SHIFT_W-1:0] k_cur, k_prm;
  logic [FW-1:0]                 fs_sel, fs_new, fs_sh;
  logic [FW:0]                   fs_calc;
  logic [VW-1:0]                 f_out;
  logic [1:0]                    nxt_ch;
  logic [adcsf_pkg::INTV_W-1:0]  cd_dec;
  logic [PW-1:0]                 prod;
  logic [QW-1:0]                 quo;

  assign status.temp_avg = !kind_r && (cur_r >= adcsf_pkg::IDX_INT);
  assign status.sum_last = (cnt_r == CNT_W'(SAMPLES - 1));

  assign res_index  = ridx_r;
  assign res_value  = rval_r;
  assign next_index = cur_r;
  assign mux_code   = adcsf_pkg::mux_code_of(cur_r);

  always_comb begin
    k_cur   = adcsf_pkg::shift_sat(cur_r[0] ? cfg.current_shift : cfg.voltage_shift);
    k_prm   = adcsf_pkg::shift_sat(pidx_r[0] ? cfg.current_shift : cfg.voltage_shift);
    fs_sel  = fsum_r[cur_r[1:0]];
    fs_calc = {1'b0, fs_sel} - ({1'b0, fs_sel} >> k_cur) + (FW + 1)'(samp_r);
    fs_new  = fs_calc[FW-1:0];
    fs_sh   = fs_new >> k_cur;
    f_out   = (fs_sh > FW'(VAL_MAX)) ? VW'(VAL_MAX) : fs_sh[VW-1:0];
    nxt_ch  = cur_r[1:0] + 2'd1;
    cd_dec  = cd_r - 1'b1;

    prod = PW'(acc_r) * PW'(RECIP);
    quo  = prod[PW-1:RSH];

    kind_nxt     = kind_r;
    pidx_nxt     = pidx_r;
    samp_nxt     = samp_r;
    fsum_nxt     = fsum_r;
    hist_nxt     = hist_r;
    slot_nxt     = slot_r;
    cur_nxt      = cur_r;
    saved_nxt    = saved_r;
    cd_nxt       = cd_r;
    last_ext_nxt = last_ext_r;
    tsel_nxt     = tsel_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    ridx_nxt     = ridx_r;
    rval_nxt     = rval_r;

    if (cmd.latch) begin
      kind_nxt = in_kind;
      pidx_nxt = in_prime_index;
      samp_nxt = (CMP_W'(in_sample) > CMP_W'(VAL_MAX)) ? VW'(VAL_MAX) : in_sample;
    end

    if (cmd.exec) begin
      cnt_nxt = '0;
      acc_nxt = '0;
      if (kind_r) begin
        // Prime: seed one channel, the sequence does not move.
        ridx_nxt = pidx_r;
        rval_nxt = '0;
        if (pidx_r < adcsf_pkg::IDX_INT) begin
          fsum_nxt[pidx_r[1:0]] = FW'(samp_r) << k_prm;
          rval_nxt = samp_r;
        end else if (pidx_r <= adcsf_pkg::IDX_EXT) begin
          for (int i = 0; i < SAMPLES; i++) begin
            hist_nxt[pidx_r[0]][i] = samp_r;
          end
          rval_nxt = samp_r;
        end
      end else begin
        ridx_nxt = cur_r;
        if (cur_r < adcsf_pkg::IDX_INT) begin
          fsum_nxt[cur_r[1:0]] = fs_new;
          rval_nxt = f_out;
          cur_nxt  = {1'b0, nxt_ch};
          cd_nxt   = cd_dec;
          if (cd_dec == '0) begin
            cd_nxt       = cfg.temp_interval;
            saved_nxt    = {1'b0, nxt_ch};
            cur_nxt      = last_ext_r ? adcsf_pkg::IDX_INT : adcsf_pkg::IDX_EXT;
            last_ext_nxt = !last_ext_r;
          end
        end else begin
          // Temperature reading: store it, then average the sensor history.
          tsel_nxt = (cur_r == adcsf_pkg::IDX_EXT);
          hist_nxt[cur_r == adcsf_pkg::IDX_EXT][slot_r] = samp_r;
          if (cur_r == adcsf_pkg::IDX_EXT) begin
            slot_nxt = (slot_r == SLOT_W'(SAMPLES - 1)) ? '0 : slot_r + 1'b1;
          end
          cur_nxt = {1'b0, saved_r[1:0]};
        end
      end
    end

    if (cmd.sum_en) begin
      acc_nxt = acc_r + DIV_W'(hist_r[tsel_r][cnt_r]);
      cnt_nxt = cnt_r + 1'b1;
    end

    if (cmd.div_load) begin
      acc_nxt = acc_r + DIV_W'(SAMPLES / 2);
    end

    if (cmd.div_step) begin
      rval_nxt = (CMP_W'(quo) > CMP_W'(VAL_MAX)) ? VW'(VAL_MAX) : quo[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < adcsf_pkg::FILTERS; f++) begin
        fsum_r[f] <= '0;
      end
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < SAMPLES; i++) begin
          hist_r[s][i] <= '0;
        end
      end
      slot_r     <= '0;
      cur_r      <= '0;
      saved_r    <= '0;
      cd_r       <= adcsf_pkg::INTV_RST;
      last_ext_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      fsum_r     <= fsum_nxt;
      hist_r     <= hist_nxt;
      slot_r     <= slot_nxt;
      cur_r      <= cur_nxt;
      saved_r    <= saved_nxt;
      cd_r       <= cd_nxt;
      last_ext_r <= last_ext_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pidx_r <= pidx_nxt;
    samp_r <= samp_nxt;
    tsel_r <= tsel_nxt;
    acc_r  <= acc_nxt;
    ridx_r <= ridx_nxt;
    rval_r <= rval_nxt;
  end

endmodule
